FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sort engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SHS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property violated");
// Expression must never be true outside reset.
`define SHS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");
`else
`define SHS_ASSERT(lbl, clk, rst_n, prop)
`define SHS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/shsort_pkg.sv
// Shared types, codes and the sort microprogram for the shell sort engine.
package shsort_pkg;

	localparam int ACT_W   = 2;
	localparam int POS_W   = 10;
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 11;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// Request action codes
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SORT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// Microprogram steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP_TEST,
		ST_I_TEST,
		ST_GAP_HALVE,
		ST_HOLD,
		ST_CMP,
		ST_SHIFT,
		ST_J_TEST,
		ST_PLACE,
		ST_DONE,
		ST_RD_OUT
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_DISPATCH,
		C_GAP_ZERO,
		C_I_GE_N,
		C_GREATER,
		C_J_GE_GAP
	} cond_t;

	typedef enum logic [1:0] {R_NONE, R_I, R_JG}       rd_op_t;
	typedef enum logic [1:0] {W_NONE, W_SHIFT, W_HELD} wr_op_t;
	typedef enum logic       {G_KEEP, G_HALVE}         gap_op_t;
	typedef enum logic [1:0] {I_KEEP, I_LOAD, I_INC}   i_op_t;
	typedef enum logic [1:0] {J_KEEP, J_LOAD, J_SUB}   j_op_t;
	typedef enum logic [1:0] {O_NONE, O_DONE, O_READ}  out_op_t;

	typedef struct packed {
		cond_t   cond;
		step_t   jmp;     // taken target
		step_t   nxt;     // fall-through target
		rd_op_t  rd_op;
		wr_op_t  wr_op;
		gap_op_t gap_op;
		i_op_t   i_op;
		j_op_t   j_op;
		logic    held_ld;
		out_op_t out_op;
	} ctrl_t;

	// Control store: one word per step.
	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t w;
		w = '{cond: C_ALWAYS, jmp: ST_IDLE, nxt: ST_IDLE, rd_op: R_NONE, wr_op: W_NONE,
			gap_op: G_KEEP, i_op: I_KEEP, j_op: J_KEEP, held_ld: 1'b0, out_op: O_NONE};
		unique case (s)
			ST_IDLE: begin
				w.cond = C_DISPATCH;
				w.jmp  = ST_GAP_TEST;
			end
			ST_GAP_TEST: begin
				w.cond = C_GAP_ZERO;
				w.jmp  = ST_DONE;
				w.nxt  = ST_I_TEST;
				w.i_op = I_LOAD;
			end
			ST_I_TEST: begin
				w.cond  = C_I_GE_N;
				w.jmp   = ST_GAP_HALVE;
				w.nxt   = ST_HOLD;
				w.rd_op = R_I;
				w.j_op  = J_LOAD;
			end
			ST_GAP_HALVE: begin
				w.jmp    = ST_GAP_TEST;
				w.nxt    = ST_GAP_TEST;
				w.gap_op = G_HALVE;
			end
			ST_HOLD: begin
				w.jmp     = ST_CMP;
				w.nxt     = ST_CMP;
				w.rd_op   = R_JG;
				w.held_ld = 1'b1;
			end
			ST_CMP: begin
				w.cond = C_GREATER;
				w.jmp  = ST_SHIFT;
				w.nxt  = ST_PLACE;
			end
			ST_SHIFT: begin
				w.jmp   = ST_J_TEST;
				w.nxt   = ST_J_TEST;
				w.wr_op = W_SHIFT;
				w.j_op  = J_SUB;
			end
			ST_J_TEST: begin
				w.cond  = C_J_GE_GAP;
				w.jmp   = ST_CMP;
				w.nxt   = ST_PLACE;
				w.rd_op = R_JG;
			end
			ST_PLACE: begin
				w.jmp   = ST_I_TEST;
				w.nxt   = ST_I_TEST;
				w.wr_op = W_HELD;
				w.i_op  = I_INC;
			end
			ST_DONE: begin
				w.out_op = O_DONE;
			end
			ST_RD_OUT: begin
				w.out_op = O_READ;
			end
			default: begin
				w.jmp = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/shsort_if.sv
// Channel interfaces of the shell sort engine: request, response, config write.
interface shsort_req_if;
	logic                                     valid;
	logic                                     ready;
	logic        [shsort_pkg::ACT_W-1:0]      action;
	logic        [shsort_pkg::POS_W-1:0]      position;
	logic signed [shsort_pkg::VAL_W-1:0]      element_value;

	modport source (output valid, output action, output position, output element_value,
		input ready);
	modport sink (input valid, input action, input position, input element_value,
		output ready);
endinterface

interface shsort_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [shsort_pkg::VAL_W-1:0]      result_value;
	logic                                     sort_done;

	modport source (output valid, output result_value, output sort_done, input ready);
	modport sink (input valid, input result_value, input sort_done, output ready);
endinterface

interface shsort_cfg_if;
	logic                                     valid;
	logic                                     ready;
	logic        [shsort_pkg::LEN_W-1:0]      data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/shell_sort_engine.sv
// Shell sort engine top level: element store, microcoded sort sequencer, channels.
//
// Usage
//   req : one request per item. action WRITE stores element_value at position,
//         READ returns the stored element, SORT sorts positions below the active
//         length (min(length, DEPTH)) in ascending signed order. Any other action
//         is a no-op. Every request gives exactly one response.
//   rsp : result_value (read data, else zero) and sort_done (set for SORT only).
//   cfg : writes the length register; always ready. Write it only while the
//         engine is idle with no request outstanding.
// Timing / throughput
//   WRITE and no-op: response registered at the accept edge, one per cycle while the
//         response register is free or draining.
//   READ: data read into a register at the accept edge, loaded by the RD_OUT step.
//   SORT: run by a one-step-per-cycle sequencer; the store has one read port and
//         one write port.
// Reset clears the sequencer, the response valid and sets length to 1024. The
// store is not cleared; reading an unwritten entry returns an undefined value.
// Backpressure: the response register holds until taken; a new request is taken
// only in idle and only when the response register is free or draining.
`include "assert_macros.svh"

module shell_sort_engine #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	shsort_cfg_if.sink         cfg,
	shsort_req_if.sink         req,
	shsort_rsp_if.source       rsp
);

	localparam int AW = $clog2(DEPTH);
	// Count width: holds the active length and any loop index
	localparam int CW = (AW + 1 > shsort_pkg::LEN_W) ? AW + 1 : shsort_pkg::LEN_W;

	// Element store
	logic signed [shsort_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic signed [shsort_pkg::VAL_W-1:0] rdata_q;

	// Control and datapath registers
	shsort_pkg::step_t                    upc_q;
	logic        [shsort_pkg::LEN_W-1:0]  length_q;
	logic        [CW-1:0]                 n_q;
	logic        [CW-1:0]                 gap_q;
	logic        [CW-1:0]                 i_q;
	logic        [CW-1:0]                 j_q;
	logic signed [shsort_pkg::VAL_W-1:0]  held_q;

	logic                                 out_valid_q;
	logic signed [shsort_pkg::VAL_W-1:0]  out_value_q;
	logic                                 out_done_q;

	shsort_pkg::ctrl_t                    ctrl;
	shsort_pkg::step_t                    upc_d;
	logic                                 in_ready;
	logic                                 accept;
	logic                                 pos_ok;
	logic        [CW-1:0]                 n_act;
	logic        [CW-1:0]                 jg;
	logic                                 cond_hit;

	logic                                 mem_we;
	logic        [AW-1:0]                 mem_wa;
	logic signed [shsort_pkg::VAL_W-1:0]  mem_wd;
	logic                                 mem_re;
	logic        [AW-1:0]                 mem_ra;

	logic                                 out_ld;
	logic signed [shsort_pkg::VAL_W-1:0]  out_value_d;
	logic                                 out_done_d;

	assign ctrl      = shsort_pkg::ucode_rom(upc_q);
	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.sort_done    = out_done_q;

	assign in_ready = (upc_q == shsort_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept   = req.valid && in_ready;
	assign pos_ok   = CW'(req.position) < CW'(DEPTH);
	assign n_act    = (CW'(length_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(length_q);
	assign jg       = j_q - gap_q;

	// Branch condition
	always_comb begin
		unique case (ctrl.cond)
			shsort_pkg::C_GAP_ZERO: cond_hit = (gap_q == '0);
			shsort_pkg::C_I_GE_N:   cond_hit = (i_q >= n_q);
			shsort_pkg::C_GREATER:  cond_hit = (rdata_q > held_q);
			shsort_pkg::C_J_GE_GAP: cond_hit = (j_q >= gap_q);
			shsort_pkg::C_DISPATCH: cond_hit = accept && (req.action == shsort_pkg::ACT_SORT);
			default:                cond_hit = 1'b1;
		endcase
	end

	// Next step; idle also dispatches in-range reads to the read-out step
	always_comb begin
		upc_d = cond_hit ? ctrl.jmp : ctrl.nxt;
		if (ctrl.cond == shsort_pkg::C_DISPATCH && accept &&
				req.action == shsort_pkg::ACT_READ && pos_ok) begin
			upc_d = shsort_pkg::ST_RD_OUT;
		end
	end

	// Store ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = j_q[AW-1:0];
		mem_wd = held_q;
		unique case (ctrl.wr_op)
			shsort_pkg::W_SHIFT: begin
				mem_we = 1'b1;
				mem_wd = rdata_q;
			end
			shsort_pkg::W_HELD: begin
				mem_we = 1'b1;
			end
			default: begin
				if (accept && req.action == shsort_pkg::ACT_WRITE && pos_ok) begin
					mem_we = 1'b1;
					mem_wa = AW'(req.position);
					mem_wd = req.element_value;
				end
			end
		endcase

		mem_re = 1'b0;
		mem_ra = i_q[AW-1:0];
		unique case (ctrl.rd_op)
			shsort_pkg::R_I: begin
				mem_re = 1'b1;
			end
			shsort_pkg::R_JG: begin
				mem_re = 1'b1;
				mem_ra = jg[AW-1:0];
			end
			default: begin
				if (accept && req.action == shsort_pkg::ACT_READ && pos_ok) begin
					mem_re = 1'b1;
					mem_ra = AW'(req.position);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_ra];
		end
	end

	// Response load
	always_comb begin
		out_ld      = 1'b0;
		out_value_d = '0;
		out_done_d  = 1'b0;
		unique case (ctrl.out_op)
			shsort_pkg::O_DONE: begin
				out_ld     = 1'b1;
				out_done_d = 1'b1;
			end
			shsort_pkg::O_READ: begin
				out_ld      = 1'b1;
				out_value_d = rdata_q;
			end
			default: begin
				// everything but SORT and in-range READ answers at once
				out_ld = accept && (req.action != shsort_pkg::ACT_SORT) &&
					!(req.action == shsort_pkg::ACT_READ && pos_ok);
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= shsort_pkg::ST_IDLE;
			length_q    <= shsort_pkg::LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (cfg.valid) begin
				length_q <= cfg.data;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_value_q <= out_value_d;
			out_done_q  <= out_done_d;
		end
		if (ctrl.cond == shsort_pkg::C_DISPATCH && accept) begin
			n_q   <= n_act;
			gap_q <= n_act >> 1;
		end else if (ctrl.gap_op == shsort_pkg::G_HALVE) begin
			gap_q <= gap_q >> 1;
		end
		unique case (ctrl.i_op)
			shsort_pkg::I_LOAD: i_q <= gap_q;
			shsort_pkg::I_INC:  i_q <= i_q + CW'(1);
			default:            i_q <= i_q;
		endcase
		unique case (ctrl.j_op)
			shsort_pkg::J_LOAD: j_q <= i_q;
			shsort_pkg::J_SUB:  j_q <= jg;
			default:            j_q <= j_q;
		endcase
		if (ctrl.held_ld) begin
			held_q <= rdata_q;
		end
	end

	`SHS_NEVER(a_rsp_overrun, clk, arst_n, out_ld && out_valid_q && !rsp.ready)
	`SHS_ASSERT(a_done_slot_free, clk, arst_n, (upc_q == shsort_pkg::ST_DONE) |-> !out_valid_q)
	`SHS_ASSERT(a_wr_in_range, clk, arst_n, (ctrl.wr_op != shsort_pkg::W_NONE) |-> (j_q < n_q))
	`SHS_ASSERT(a_hold_bounds, clk, arst_n, (upc_q == shsort_pkg::ST_HOLD) |-> (i_q < n_q && i_q >= gap_q && gap_q != '0))

endmodule
